// File: design/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// command and status codes for the sorted list insert/delete block
// ----------------------------------------------------------------------------
package sli_pkg;

  // request command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  localparam int ValueW = 32;
  localparam int CountW = 5;

endpackage

// File: design/sorted_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top
// bounded sorted multiset of signed 32-bit values kept in one memory
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ----------------------
//  request   command, value                          start & !busy
//  result    status, entry_value, entry_count, last  done, one cycle each
//
//  insert: one memory read and one write per cycle while shifting entries up
//    from the top; delete and dump walk the list from entry 0, one entry per
//    cycle through the single read port
//  full insert, insert into an empty list, delete on an empty list, empty dump
//    and command 3 finish in the accept cycle and keep busy low
//  reset: synchronous, clears the state, the entry count and done; memory needs no clearing
//  dump results come on consecutive cycles; the receiver cannot stall them
//
module sorted_list_insert_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        command,
  input  logic signed [sli_pkg::ValueW-1:0] value,
  output logic                              busy,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [sli_pkg::ValueW-1:0] entry_value,
  output logic [sli_pkg::CountW-1:0]        entry_count,
  output logic                              last
);

  import sli_pkg::*;

  // address and count widths follow the capacity
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INSF,
    S_DEL,
    S_DUMP
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [AW-1:0]           idx;
  logic signed [ValueW-1:0] val;
  logic                    found;

  // entry memory, synchronous read into a register
  logic signed [ValueW-1:0] mem [CAPACITY];
  logic signed [ValueW-1:0] rd_data;
  logic [AW-1:0]           ra;
  logic [AW-1:0]           wa;
  logic signed [ValueW-1:0] wd;
  logic                    we;

  logic                    accept;
  logic [AW-1:0]           last_idx;
  logic                    hit;
  logic                    shift_up;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign last_idx = AW'(count - CW'(1));
  // delete: match seen earlier or at the entry just read
  assign hit      = found || (rd_data == val);
  // insert: entry just read sits above the new value and moves up one slot
  assign shift_up = (rd_data > val);

  // memory address and write control
  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = idx;
    wd = val;
    case (state)
      S_IDLE: begin
        if (accept && command == CMD_INSERT) begin
          if (count == '0) begin
            // first entry goes straight to slot 0
            we = 1'b1;
            wa = '0;
            wd = value;
          end else begin
            // start from the top entry
            ra = last_idx;
          end
        end
      end
      S_INS: begin
        we = 1'b1;
        wa = idx;
        if (shift_up) begin
          wd = rd_data;
          ra = idx - AW'(2);
        end else begin
          wd = val;
        end
      end
      S_INSF: begin
        // every entry moved up, new value lands at the bottom
        we = 1'b1;
        wa = '0;
        wd = val;
      end
      S_DEL: begin
        // after the match, close the gap by moving each entry down
        if (found) begin
          we = 1'b1;
          wa = idx - AW'(1);
          wd = rd_data;
        end
        ra = idx + AW'(1);
      end
      S_DUMP: begin
        ra = idx + AW'(1);
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // control state machine and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            val         <= value;
            found       <= 1'b0;
            entry_value <= '0;
            last        <= 1'b1;
            case (command)
              CMD_INSERT: begin
                if (count >= CW'(CAPACITY)) begin
                  done        <= 1'b1;
                  status      <= ST_FULL;
                  entry_count <= CountW'(count);
                end else if (count == '0) begin
                  count       <= CW'(1);
                  done        <= 1'b1;
                  status      <= ST_OK;
                  entry_count <= CountW'(1);
                end else begin
                  done  <= 1'b0;
                  idx   <= AW'(count);
                  state <= S_INS;
                end
              end
              CMD_DELETE: begin
                idx         <= '0;
                entry_count <= CountW'(count);
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= ST_NOT_FOUND;
                end else begin
                  done  <= 1'b0;
                  state <= S_DEL;
                end
              end
              CMD_DUMP: begin
                idx         <= '0;
                entry_count <= CountW'(count);
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  done  <= 1'b0;
                  state <= S_DUMP;
                end
              end
              default: begin
                // unused code, no result
                done  <= 1'b0;
                state <= S_IDLE;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_INS: begin
          if (shift_up) begin
            done <= 1'b0;
            if (idx == AW'(1)) begin
              state <= S_INSF;
            end else begin
              idx <= idx - AW'(1);
            end
          end else begin
            count       <= count + CW'(1);
            entry_count <= CountW'(count + CW'(1));
            status      <= ST_OK;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_INSF: begin
          count       <= count + CW'(1);
          entry_count <= CountW'(count + CW'(1));
          status      <= ST_OK;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_DEL: begin
          if (idx == last_idx) begin
            if (hit) begin
              count       <= count - CW'(1);
              entry_count <= CountW'(count - CW'(1));
              status      <= ST_OK;
            end else begin
              status <= ST_NOT_FOUND;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            done  <= 1'b0;
            found <= hit;
            idx   <= idx + AW'(1);
          end
        end
        S_DUMP: begin
          done        <= 1'b1;
          status      <= ST_OK;
          entry_value <= rd_data;
          if (idx == last_idx) begin
            last  <= 1'b1;
            state <= S_IDLE;
          end else begin
            last <= 1'b0;
            idx  <= idx + AW'(1);
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a full report only comes with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CountW'(CAPACITY)))
    else $error("full reported below capacity");

  // every multi-cycle request ends with a result
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("request finished without a result");

  // dump results come back to back up to the last one
  a_dump_stream: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> done)
    else $error("gap in dump results");
`endif

endmodule
